>>> hw/rtl/tcp_congestion_window_control_defines.svh
// ----------------------------------------------------------------------------
// tcp congestion window control assertion macros
// shared concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef TCP_CONGESTION_WINDOW_CONTROL_DEFINES_SVH
`define TCP_CONGESTION_WINDOW_CONTROL_DEFINES_SVH

`ifndef SYNTH
`define CWC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define CWC_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define CWC_ASSERT(name, clk, rst_n, prop)
`define CWC_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

>>> hw/rtl/cwc_pkg.sv
// ----------------------------------------------------------------------------
// cwc_pkg
// types, codes and helpers of the congestion window control block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cwc_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  localparam logic [7:0]  DUP_ACK_LIMIT = 8'd3;
  localparam logic [31:0] WIN_MAX       = 32'hFFFF_FFFF;

  localparam logic [15:0] SEG_RST  = 16'd536;
  localparam logic [7:0]  IWS_RST  = 8'd1;
  localparam logic [31:0] ITHR_RST = 32'd65535;
  localparam logic [31:0] THR_RST  = 32'd65535;

  typedef enum logic [1:0] {
    MODE_NEW_ACK = 2'd0,
    MODE_DUP_ACK = 2'd1,
    MODE_TIMEOUT = 2'd2,
    MODE_START   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_SEGMENT_SIZE  = 2'd0,
    CFG_INIT_SEGMENTS = 2'd1,
    CFG_INIT_THRESH   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_GROW,
    OP_LOSS,
    OP_TIMEOUT,
    OP_START
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIVS,
    ST_DIV,
    ST_RES
  } state_e;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  dup_count;
    logic [31:0] receiver_window;
    logic        conn_closed;
    logic        all_acked;
  } cwc_in_t;

  typedef struct packed {
    logic [31:0] cong_window;
    logic [31:0] slow_start_threshold;
    logic [31:0] send_window;
    logic        rewind;
    logic        timer_backoff;
  } cwc_out_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] rxw;
  } cmd_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? WIN_MAX : s[31:0];
  endfunction

endpackage

>>> hw/rtl/tcp_congestion_window_control.sv
// ----------------------------------------------------------------------------
// tcp_congestion_window_control
// congestion window and slow-start threshold tracking with tahoe loss reaction
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// event     in   push_i / full_o    item_i (cwc_in_t)
// result    out  pop_i / empty_o    res_o (cwc_out_t)
// config    in   cfg_we_i           cfg_idx_i, cfg_wdata_i
//
// an event passes IDLE, EXEC and RES; congestion avoidance adds DIVS and DIV after EXEC,
// running the radix-2 divider over 32 quotient bits for seg*seg/window
// the back end handles one event at a time; a two-entry queue takes new events meanwhile
// a result waits in the output register until popped, the back end stalls behind it
// reset: window 0, threshold 65535, config at 536 / 1 / 65535
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcp_congestion_window_control import cwc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  cwc_in_t     item_i,
  output logic        empty_o,
  input  logic        pop_i,
  output cwc_out_t    res_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  logic        q_push, q_full, q_pop, q_empty;
  cmd_t        q_wcmd, q_rcmd;
  div_req_t    div_req;
  logic        div_done;
  logic [31:0] div_quot;

  cwc_front u_front (
    .push_i   (push_i),
    .full_o   (full_o),
    .item_i   (item_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (q_wcmd)
  );

  cwc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wcmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rcmd)
  );

  cwc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  cwc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_empty_i (q_empty),
    .cmd_i       (q_rcmd),
    .cmd_pop_o   (q_pop),
    .div_req_o   (div_req),
    .div_done_i  (div_done),
    .div_quot_i  (div_quot),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .res_o       (res_o)
  );

endmodule

>>> hw/rtl/cwc_front.sv
// ----------------------------------------------------------------------------
// cwc_front
// accepts events and classifies them into commands for the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cwc_front import cwc_pkg::*; (
  input  logic    push_i,
  output logic    full_o,
  input  cwc_in_t item_i,
  input  logic    q_full_i,
  output logic    q_push_o,
  output cmd_t    q_cmd_o
);

  op_e op;

  always_comb begin
    case (item_i.mode)
      MODE_NEW_ACK: op = OP_GROW;
      MODE_DUP_ACK: op = (item_i.dup_count == DUP_ACK_LIMIT) ? OP_LOSS : OP_NONE;
      MODE_TIMEOUT: begin
        op = (!item_i.conn_closed && !item_i.all_acked) ? OP_TIMEOUT : OP_NONE;
      end
      MODE_START:   op = OP_START;
      default:      op = OP_NONE;
    endcase
  end

  assign full_o        = q_full_i;
  assign q_push_o      = push_i && !q_full_i;
  assign q_cmd_o.op    = op;
  assign q_cmd_o.rxw   = item_i.receiver_window;

endmodule

>>> hw/rtl/cwc_queue.sv
// ----------------------------------------------------------------------------
// cwc_queue
// short command queue between the front and the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cwc_queue import cwc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t data_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hw/rtl/cwc_div.sv
// ----------------------------------------------------------------------------
// cwc_div
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cwc_div import cwc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_req_t    req_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);

  logic [31:0] rem_q, rem_d;
  logic [31:0] dvd_q, dvd_d;
  logic [31:0] dvs_q, dvs_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] shifted;
  logic [32:0] trial;

  assign shifted = {rem_q, dvd_q[31]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      cnt_d  = '1;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        dvd_d = {dvd_q[30:0], 1'b1};
      end else begin
        rem_d = shifted[31:0];
        dvd_d = {dvd_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

>>> hw/rtl/cwc_back.sv
// ----------------------------------------------------------------------------
// cwc_back
// window and threshold state, config registers and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tcp_congestion_window_control_defines.svh"

module cwc_back import cwc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        cmd_empty_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  output div_req_t    div_req_o,
  input  logic        div_done_i,
  input  logic [31:0] div_quot_i,
  output logic        empty_o,
  input  logic        pop_i,
  output cwc_out_t    res_o
);

  state_e      state_q, state_d;
  logic [15:0] seg_q;
  logic [7:0]  iws_q;
  logic [31:0] ithr_q;
  logic [31:0] win_q, win_d;
  logic [31:0] thr_q, thr_d;
  logic [31:0] sq_q, sq_d;
  op_e         op_q, op_d;
  logic [31:0] rxw_q, rxw_d;
  logic        rewind_q, rewind_d;
  logic        backoff_q, backoff_d;
  logic        out_valid_q, out_valid_d;
  cwc_out_t    out_q, out_d;
  logic        out_load;
  logic        slow_start;
  logic [31:0] half;
  logic [31:0] floor2;
  logic [23:0] start_prod;
  logic [31:0] add;

  assign slow_start = (win_q < thr_q) || (win_q == '0);
  assign half       = ((rxw_q < win_q) ? rxw_q : win_q) >> 1;
  assign floor2     = {15'd0, seg_q, 1'b0};
  assign start_prod = iws_q * seg_q;
  assign add        = (div_quot_i == '0) ? 32'd1 : div_quot_i;
  assign out_load   = (state_q == ST_RES) && (!out_valid_q || pop_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (!cmd_empty_i) state_d = ST_EXEC;
      ST_EXEC: state_d = (op_q == OP_GROW && !slow_start) ? ST_DIVS : ST_RES;
      ST_DIVS: state_d = ST_DIV;
      ST_DIV:  if (div_done_i) state_d = ST_RES;
      ST_RES:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o          = (state_q == ST_IDLE) && !cmd_empty_i;
    div_req_o.start    = (state_q == ST_DIVS);
    div_req_o.dividend = sq_q;
    div_req_o.divisor  = win_q;
    win_d     = win_q;
    thr_d     = thr_q;
    sq_d      = sq_q;
    op_d      = op_q;
    rxw_d     = rxw_q;
    rewind_d  = rewind_q;
    backoff_d = backoff_q;
    out_d     = out_q;
    case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          op_d      = cmd_i.op;
          rxw_d     = cmd_i.rxw;
          rewind_d  = 1'b0;
          backoff_d = 1'b0;
        end
      end
      ST_EXEC: begin
        case (op_q)
          OP_GROW: begin
            if (slow_start) begin
              win_d = sat_add(win_q, {16'd0, seg_q});
            end else begin
              sq_d = seg_q * seg_q;
            end
          end
          OP_LOSS, OP_TIMEOUT: begin
            thr_d     = (half > floor2) ? half : floor2;
            win_d     = {16'd0, seg_q};
            rewind_d  = 1'b1;
            backoff_d = (op_q == OP_TIMEOUT);
          end
          OP_START: begin
            win_d = {8'd0, start_prod};
            thr_d = ithr_q;
          end
          default: ;
        endcase
      end
      ST_DIV: begin
        if (div_done_i) begin
          win_d = sat_add(win_q, add);
        end
      end
      ST_RES: begin
        if (out_load) begin
          out_d.cong_window          = win_q;
          out_d.slow_start_threshold = thr_q;
          out_d.send_window          = (rxw_q < win_q) ? rxw_q : win_q;
          out_d.rewind               = rewind_q;
          out_d.timer_backoff        = backoff_q;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      win_q       <= '0;
      thr_q       <= THR_RST;
      seg_q       <= SEG_RST;
      iws_q       <= IWS_RST;
      ithr_q      <= ITHR_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      win_q       <= win_d;
      thr_q       <= thr_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SEGMENT_SIZE:  seg_q  <= cfg_wdata_i[15:0];
          CFG_INIT_SEGMENTS: iws_q  <= cfg_wdata_i[7:0];
          CFG_INIT_THRESH:   ithr_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q      <= sq_d;
    op_q      <= op_d;
    rxw_q     <= rxw_d;
    rewind_q  <= rewind_d;
    backoff_q <= backoff_d;
    out_q     <= out_d;
  end

  assign empty_o = !out_valid_q;
  assign res_o   = out_q;

  `CWC_ASSERT(a_result_held, clk_i, rst_ni, out_valid_q && !pop_i |=> out_valid_q)
  `CWC_ASSERT(a_div_nonzero, clk_i, rst_ni, state_q == ST_DIV |-> win_q != '0)
  `CWC_ASSERT(a_done_in_div, clk_i, rst_ni, div_done_i |-> state_q == ST_DIV)
  `CWC_ASSERT_NEVER(a_pop_busy, clk_i, rst_ni, cmd_pop_o && state_q != ST_IDLE)

endmodule

>>> bench/tcp_congestion_window_control_test.sv
// ----------------------------------------------------------------------------
// tcp_congestion_window_control_test
// self-checking bench: events go in through the push side, results are popped
// at random and compared field by field with a tahoe window predictor kept here
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcp_congestion_window_control_test import cwc_pkg::*; ();

  logic        clk_i;
  logic        rst_ni;
  logic        push_i;
  logic        full_o;
  cwc_in_t     item_i;
  logic        empty_o;
  logic        pop_i;
  cwc_out_t    res_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  tcp_congestion_window_control u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .item_i      (item_i),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // predicted block state and configuration
  logic [15:0] seg_q;
  logic [7:0]  iws_q;
  logic [31:0] ithr_q;
  logic [31:0] win_q;
  logic [31:0] thr_q;

  cwc_out_t    expected_windows[$];
  int unsigned mismatches;
  int unsigned events_sent;
  int unsigned results_checked;
  int unsigned losses_seen;
  bit          steady_flow;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("timeout after %0d events, %0d results", events_sent, results_checked);
    $display("end of test: mismatches");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic logic [31:0] grow(input logic [31:0] win, input logic [31:0] add);
    logic [32:0] s;
    s = {1'b0, win} + {1'b0, add};
    return s[32] ? WIN_MAX : s[31:0];
  endfunction

  function automatic void apply_loss(input logic [31:0] rxw);
    logic [31:0] half;
    logic [31:0] floor2;
    half   = ((rxw < win_q) ? rxw : win_q) >> 1;
    floor2 = {15'd0, seg_q, 1'b0};
    thr_q  = (half > floor2) ? half : floor2;
    win_q  = {16'd0, seg_q};
  endfunction

  function automatic cwc_out_t window_update(input cwc_in_t ev);
    cwc_out_t    r;
    logic [63:0] quotient;
    r = '0;
    case (ev.mode)
      MODE_NEW_ACK: begin
        if (win_q < thr_q || win_q == 32'd0) begin
          win_q = grow(win_q, {16'd0, seg_q});
        end else begin
          quotient = (64'(seg_q) * 64'(seg_q)) / 64'(win_q);
          if (quotient == 64'd0) quotient = 64'd1;
          if (quotient > 64'(WIN_MAX)) quotient = 64'(WIN_MAX);
          win_q = grow(win_q, quotient[31:0]);
        end
      end
      MODE_DUP_ACK: begin
        if (ev.dup_count == DUP_ACK_LIMIT) begin
          apply_loss(ev.receiver_window);
          r.rewind = 1'b1;
        end
      end
      MODE_TIMEOUT: begin
        if (!ev.conn_closed && !ev.all_acked) begin
          apply_loss(ev.receiver_window);
          r.rewind        = 1'b1;
          r.timer_backoff = 1'b1;
        end
      end
      MODE_START: begin
        win_q = 32'(iws_q) * 32'(seg_q);
        thr_q = ithr_q;
      end
      default: ;
    endcase
    r.cong_window          = win_q;
    r.slow_start_threshold = thr_q;
    r.send_window          = (ev.receiver_window < win_q) ? ev.receiver_window : win_q;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 15) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 4);
  endfunction

  function automatic cwc_in_t make_event(input mode_e m, input logic [7:0] dup,
                                         input logic [31:0] rxw, input logic closed,
                                         input logic acked);
    cwc_in_t ev;
    ev.mode            = m;
    ev.dup_count       = dup;
    ev.receiver_window = rxw;
    ev.conn_closed     = closed;
    ev.all_acked       = acked;
    return ev;
  endfunction

  function automatic cwc_in_t random_event();
    int unsigned r;
    mode_e       m;
    logic [7:0]  dup;
    logic [31:0] rxw;
    r = $urandom_range(0, 99);
    if (r < 60) m = MODE_NEW_ACK;
    else if (r < 78) m = MODE_DUP_ACK;
    else if (r < 92) m = MODE_TIMEOUT;
    else m = MODE_START;
    dup = $urandom_range(0, 1) ? DUP_ACK_LIMIT : 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0: rxw = 32'd0;
      1: rxw = WIN_MAX;
      2, 3: rxw = $urandom;
      default: rxw = win_q + 32'($urandom_range(0, 4000)) - 32'd2000;
    endcase
    return make_event(m, dup, rxw, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
  endfunction

  // one event transfer, then an optional random gap
  task automatic send_event(input cwc_in_t ev);
    int unsigned gap;
    push_i <= 1'b1;
    item_i <= ev;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    expected_windows.push_back(window_update(ev));
    events_sent++;
    if (!steady_flow && $urandom_range(0, 3) == 0) begin
      gap = pick_gap();
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    push_i <= 1'b0;
    @(posedge clk_i);
    while (expected_windows.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_config(input logic [15:0] seg, input logic [7:0] iws,
                             input logic [31:0] ithr);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SEGMENT_SIZE;
    cfg_wdata_i <= {16'd0, seg};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_INIT_SEGMENTS;
    cfg_wdata_i <= {24'd0, iws};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_INIT_THRESH;
    cfg_wdata_i <= ithr;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    seg_q  = seg;
    iws_q  = iws;
    ithr_q = ithr;
  endtask

  task automatic test_events_before_start();
    send_event(make_event(MODE_NEW_ACK, 8'd0, 32'd100, 1'b0, 1'b0));
    send_event(make_event(MODE_DUP_ACK, 8'd2, WIN_MAX, 1'b0, 1'b0));
    send_event(make_event(MODE_DUP_ACK, DUP_ACK_LIMIT, WIN_MAX, 1'b0, 1'b0));
    send_event(make_event(MODE_TIMEOUT, 8'd0, 32'd1000, 1'b1, 1'b0));
    send_event(make_event(MODE_TIMEOUT, 8'd0, 32'd1000, 1'b0, 1'b1));
    send_event(make_event(MODE_TIMEOUT, 8'd0, 32'd0, 1'b0, 1'b0));
    send_event(make_event(MODE_DUP_ACK, 8'd255, 32'd0, 1'b1, 1'b1));
    send_event(make_event(MODE_DUP_ACK, 8'd4, 32'h5555_AAAA, 1'b0, 1'b0));
  endtask

  task automatic test_start_extremes();
    load_config(16'hFFFF, 8'hFF, WIN_MAX);
    send_event(make_event(MODE_START, 8'hFF, WIN_MAX, 1'b1, 1'b1));
    send_event(make_event(MODE_NEW_ACK, 8'd0, 32'hAAAA_5555, 1'b0, 1'b0));
    send_event(make_event(MODE_TIMEOUT, 8'd0, WIN_MAX, 1'b0, 1'b0));
    load_config(16'd1, 8'd0, 32'd0);
    send_event(make_event(MODE_START, 8'd0, 32'd0, 1'b0, 1'b0));
    send_event(make_event(MODE_NEW_ACK, 8'd0, WIN_MAX, 1'b0, 1'b0));
    send_event(make_event(MODE_NEW_ACK, 8'd0, WIN_MAX, 1'b0, 1'b0));
    send_event(make_event(MODE_NEW_ACK, 8'd0, 32'd1, 1'b0, 1'b0));
  endtask

  task automatic test_zero_segment();
    load_config(16'd100, 8'd3, 32'd0);
    send_event(make_event(MODE_START, 8'd0, WIN_MAX, 1'b0, 1'b0));
    load_config(16'd0, 8'd3, 32'd0);
    send_event(make_event(MODE_NEW_ACK, 8'd0, WIN_MAX, 1'b0, 1'b0));
    send_event(make_event(MODE_DUP_ACK, DUP_ACK_LIMIT, WIN_MAX, 1'b0, 1'b0));
    send_event(make_event(MODE_NEW_ACK, 8'd0, WIN_MAX, 1'b0, 1'b0));
    send_event(make_event(MODE_START, 8'd0, 32'd7, 1'b0, 1'b0));
    send_event(make_event(MODE_NEW_ACK, 8'd0, 32'd7, 1'b0, 1'b0));
    send_event(make_event(MODE_TIMEOUT, 8'd0, 32'd5, 1'b0, 1'b0));
  endtask

  // a one-byte window with a full-size segment gives the largest single step
  task automatic test_window_jump();
    load_config(16'd1, 8'd1, 32'd0);
    send_event(make_event(MODE_START, 8'd0, WIN_MAX, 1'b0, 1'b0));
    load_config(16'hFFFF, 8'd1, 32'd0);
    send_event(make_event(MODE_NEW_ACK, 8'd0, WIN_MAX, 1'b0, 1'b0));
    send_event(make_event(MODE_NEW_ACK, 8'd0, WIN_MAX, 1'b0, 1'b0));
    send_event(make_event(MODE_DUP_ACK, DUP_ACK_LIMIT, WIN_MAX, 1'b0, 1'b0));
  endtask

  // slow start climb with full-size segments, no stalls on either side
  task automatic test_slow_start_climb();
    load_config(16'hFFFF, 8'hFF, WIN_MAX);
    steady_flow = 1'b1;
    send_event(make_event(MODE_START, 8'd0, WIN_MAX, 1'b0, 1'b0));
    repeat (24) begin
      send_event(make_event(MODE_NEW_ACK, 8'($urandom), $urandom, 1'b0, 1'b0));
    end
    repeat (3) send_event(make_event(MODE_NEW_ACK, 8'd0, WIN_MAX, 1'b0, 1'b0));
    send_event(make_event(MODE_TIMEOUT, 8'd0, WIN_MAX, 1'b0, 1'b0));
    steady_flow = 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] seg, input logic [7:0] iws,
                           input logic [31:0] ithr, input int unsigned count);
    cwc_in_t ev;
    load_config(seg, iws, ithr);
    send_event(make_event(MODE_START, 8'd0, $urandom, 1'b0, 1'b0));
    for (int unsigned i = 1; i < count; i++) begin
      steady_flow = ((i / 64) % 4) == 3;
      ev = random_event();
      send_event(ev);
    end
    steady_flow = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_phase(SEG_RST, IWS_RST, ITHR_RST, 310);
    run_phase(16'd1, 8'hFF, WIN_MAX, 310);
    run_phase(16'hFFFF, 8'd0, 32'd0, 310);
    run_phase(16'($urandom_range(1, 65535)), 8'($urandom), $urandom, 310);
    run_phase(16'd1460, 8'd10, 32'($urandom_range(0, 200000)), 310);
    run_phase(16'd0, 8'($urandom), $urandom, 310);
  endtask

  // result side: random stalls, none while the flow is steady
  initial begin : pop_driver
    int unsigned stall_left;
    stall_left = 0;
    pop_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0 && !steady_flow) begin
        pop_i <= 1'b0;
        stall_left--;
      end else begin
        pop_i <= 1'b1;
        stall_left = ($urandom_range(0, 5) == 0) ? pick_gap() : 0;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s got 0x%08h want 0x%08h",
                                results_checked, name, got, want));
    end
  endtask

  always @(posedge clk_i) begin : result_check
    cwc_out_t want;
    if (rst_ni && pop_i && !empty_o) begin
      if (expected_windows.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = expected_windows.pop_front();
        check_field("cong_window", res_o.cong_window, want.cong_window);
        check_field("slow_start_threshold", res_o.slow_start_threshold,
                    want.slow_start_threshold);
        check_field("send_window", res_o.send_window, want.send_window);
        check_field("rewind", 32'(res_o.rewind), 32'(want.rewind));
        check_field("timer_backoff", 32'(res_o.timer_backoff), 32'(want.timer_backoff));
        if (want.rewind) losses_seen++;
        results_checked++;
      end
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    push_i      <= 1'b0;
    item_i      <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_SEGMENT_SIZE;
    cfg_wdata_i <= '0;
    seg_q       = SEG_RST;
    iws_q       = IWS_RST;
    ithr_q      = ITHR_RST;
    win_q       = 32'd0;
    thr_q       = THR_RST;
    steady_flow = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_events_before_start();
    test_start_extremes();
    test_zero_segment();
    test_window_jump();
    test_slow_start_climb();
    test_random_traffic();

    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("run covered %0d events and %0d checked results, %0d of them loss reactions",
             events_sent, results_checked, losses_seen);
    $display("including pre-start events, zero segment size and a stall-free slow start climb");
    if (mismatches == 0 && expected_windows.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
